### rtl/gve_pkg.sv
// gve_pkg: shared types, constants and the microcode ROM of the GPS velocity estimator.
// No dependencies; used by the interfaces and every module of the block.
package gve_pkg;

    typedef logic signed [30:0] lat_t;
    typedef logic signed [31:0] lon_t;
    typedef logic        [19:0] dtime_t;
    typedef logic signed [15:0] speed_t;
    typedef logic        [15:0] scale_t;
    typedef logic        [29:0] denom_t;
    typedef logic        [4:0]  upc_t;

    localparam scale_t SCALE_RESET = 16'd32768;

    // Time snapping windows, microseconds
    localparam dtime_t SNAP1_LO  = 20'd70000;
    localparam dtime_t SNAP1_HI  = 20'd130000;
    localparam dtime_t SNAP1_VAL = 20'd100000;
    localparam dtime_t SNAP2_LO  = 20'd170000;
    localparam dtime_t SNAP2_HI  = 20'd200000 + 20'd30000;
    localparam dtime_t SNAP2_VAL = 20'd200000;

    localparam logic [29:0] K_1E6   = 30'd1000000;
    localparam logic [29:0] K_15625 = 30'd15625;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        MA_DLAT   = 3'd0,
        MA_DLON   = 3'd1,
        MA_PREV_N = 3'd2,
        MA_PREV_E = 3'd3,
        MA_SCALE  = 3'd4
    } mul_a_t;

    typedef enum logic [1:0] {
        MB_C1E6   = 2'd0,
        MB_DT     = 2'd1,
        MB_C15625 = 2'd2,
        MB_PROD   = 2'd3
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_HOLD     = 2'd0,
        ACC_LOAD     = 2'd1,
        ACC_ADD      = 2'd2,
        ACC_ADD_SHL9 = 2'd3
    } acc_op_t;

    typedef enum logic [2:0] {
        COND_NEXT       = 3'd0,
        COND_JMP        = 3'd1,
        COND_NO_INPUT   = 3'd2,
        COND_NOT_PRIMED = 3'd3,
        COND_DIV_BUSY   = 3'd4,
        COND_OUT_FULL   = 3'd5
    } cond_t;

    typedef struct packed {
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        logic    diff_en;
        logic    div_start;
        logic    div_east;
        logic    store_n;
        logic    store_e;
        logic    emit;
        logic    emit_valid;
        logic    commit;
        cond_t   cond;
        upc_t    target;
    } ctrl_t;

    // Status fed to the sequencer from the datapath and the top level
    typedef struct packed {
        logic in_fire;
        logic primed;
        logic div_busy;
        logic out_full;
    } stat_t;

    localparam upc_t STEP_IDLE       = 5'd0;
    localparam upc_t STEP_CHECK      = 5'd1;
    localparam upc_t STEP_MUL_DLAT   = 5'd2;
    localparam upc_t STEP_MUL_PN     = 5'd3;
    localparam upc_t STEP_ADD_N      = 5'd4;
    localparam upc_t STEP_DIV_N      = 5'd5;
    localparam upc_t STEP_WAIT_N     = 5'd6;
    localparam upc_t STEP_MUL_K      = 5'd7;
    localparam upc_t STEP_MUL_DLON   = 5'd8;
    localparam upc_t STEP_MUL_PE     = 5'd9;
    localparam upc_t STEP_ADD_E      = 5'd10;
    localparam upc_t STEP_DIV_E      = 5'd11;
    localparam upc_t STEP_WAIT_E     = 5'd12;
    localparam upc_t STEP_STORE_E    = 5'd13;
    localparam upc_t STEP_WAIT_OUT   = 5'd14;
    localparam upc_t STEP_EMIT       = 5'd15;
    localparam upc_t STEP_PRIME_WAIT = 5'd16;
    localparam upc_t STEP_PRIME_EMIT = 5'd17;

    function automatic ctrl_t ucode(input upc_t pc);
        ctrl_t w;
        w = '{mul_en: 1'b0, mul_a: MA_DLAT, mul_b: MB_C1E6, acc_op: ACC_HOLD,
              diff_en: 1'b0, div_start: 1'b0, div_east: 1'b0, store_n: 1'b0,
              store_e: 1'b0, emit: 1'b0, emit_valid: 1'b0, commit: 1'b0,
              cond: COND_NEXT, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:
            begin
                w.cond   = COND_NO_INPUT;
                w.target = STEP_IDLE;
            end
            STEP_CHECK:
            begin
                w.diff_en = 1'b1;
                w.cond    = COND_NOT_PRIMED;
                w.target  = STEP_PRIME_WAIT;
            end
            STEP_MUL_DLAT:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_DLAT;
                w.mul_b  = MB_C1E6;
            end
            STEP_MUL_PN:
            begin
                w.acc_op = ACC_LOAD;
                w.mul_en = 1'b1;
                w.mul_a  = MA_PREV_N;
                w.mul_b  = MB_DT;
            end
            STEP_ADD_N:
            begin
                w.acc_op = ACC_ADD;
            end
            STEP_DIV_N:
            begin
                w.div_start = 1'b1;
            end
            STEP_WAIT_N:
            begin
                w.cond   = COND_DIV_BUSY;
                w.target = STEP_WAIT_N;
            end
            STEP_MUL_K:
            begin
                w.store_n = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_a   = MA_SCALE;
                w.mul_b   = MB_C15625;
            end
            STEP_MUL_DLON:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_DLON;
                w.mul_b  = MB_PROD;
            end
            STEP_MUL_PE:
            begin
                w.acc_op = ACC_LOAD;
                w.mul_en = 1'b1;
                w.mul_a  = MA_PREV_E;
                w.mul_b  = MB_DT;
            end
            STEP_ADD_E:
            begin
                w.acc_op = ACC_ADD_SHL9;
            end
            STEP_DIV_E:
            begin
                w.div_start = 1'b1;
                w.div_east  = 1'b1;
            end
            STEP_WAIT_E:
            begin
                w.cond   = COND_DIV_BUSY;
                w.target = STEP_WAIT_E;
            end
            STEP_STORE_E:
            begin
                w.store_e = 1'b1;
            end
            STEP_WAIT_OUT:
            begin
                w.cond   = COND_OUT_FULL;
                w.target = STEP_WAIT_OUT;
            end
            STEP_EMIT:
            begin
                w.emit       = 1'b1;
                w.emit_valid = 1'b1;
                w.commit     = 1'b1;
                w.cond       = COND_JMP;
                w.target     = STEP_IDLE;
            end
            STEP_PRIME_WAIT:
            begin
                w.cond   = COND_OUT_FULL;
                w.target = STEP_PRIME_WAIT;
            end
            STEP_PRIME_EMIT:
            begin
                w.emit   = 1'b1;
                w.commit = 1'b1;
                w.cond   = COND_JMP;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_JMP;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/gve_if.sv
// gve_if: valid/ready channel interfaces for GPS fixes and speed results.
// Depends on gve_pkg for payload types.
interface gve_fix_if;
    logic            valid;
    logic            ready;
    gve_pkg::lat_t   latitude;
    gve_pkg::lon_t   longitude;
    gve_pkg::dtime_t delta_time_us;

    modport source (output valid, output latitude, output longitude, output delta_time_us,
                    input ready);
    modport sink   (input valid, input latitude, input longitude, input delta_time_us,
                    output ready);
endinterface

interface gve_speed_if;
    logic            valid;
    logic            ready;
    gve_pkg::speed_t speed_north;
    gve_pkg::speed_t speed_east;
    logic            speed_valid;

    modport source (output valid, output speed_north, output speed_east, output speed_valid,
                    input ready);
    modport sink   (input valid, input speed_north, input speed_east, input speed_valid,
                    output ready);
endinterface

### rtl/gve_divider.sv
// gve_divider: restoring divider, one quotient bit per cycle, int16-saturated result.
// Depends on gve_pkg.
module gve_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [63:0]    numer,
    input  gve_pkg::denom_t       denom,
    output logic                  busy,
    output gve_pkg::speed_t       quotient
);
    import gve_pkg::*;

    logic        busy_reg,  busy_next;
    logic [4:0]  cnt_reg,   cnt_next;
    logic [63:0] mag_reg,   mag_next;
    logic [44:0] dsh_reg,   dsh_next;
    logic        neg_reg,   neg_next;
    logic [15:0] q_reg,     q_next;
    logic        ge;

    assign ge = mag_reg >= {19'd0, dsh_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        dsh_next  = dsh_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            neg_next  = numer[63];
            mag_next  = numer[63] ? 64'(-numer) : 64'(numer);
            dsh_next  = {denom, 15'd0};
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            // first bit tested is bit 15: set means the result overflows int16
            if (ge)
            begin
                mag_next = mag_reg - {19'd0, dsh_reg};
            end
            q_next    = {q_reg[14:0], ge};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg - 5'd1;
            busy_next = (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        dsh_reg <= dsh_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    always_comb
    begin
        if (q_reg[15])
        begin
            quotient = neg_reg ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/gve_sequencer.sv
// gve_sequencer: microprogram counter, ROM fetch and conditional jumps.
// Depends on gve_pkg (control word, step codes, ROM function).
module gve_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  gve_pkg::stat_t  stat,
    output gve_pkg::ctrl_t  ctrl,
    output logic            idle
);
    import gve_pkg::*;

    upc_t pc_reg, pc_next;
    logic taken;

    assign ctrl = ucode(pc_reg);
    assign idle = (pc_reg == STEP_IDLE);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEXT:       taken = 1'b0;
            COND_JMP:        taken = 1'b1;
            COND_NO_INPUT:   taken = !stat.in_fire;
            COND_NOT_PRIMED: taken = !stat.primed;
            COND_DIV_BUSY:   taken = stat.div_busy;
            COND_OUT_FULL:   taken = stat.out_full;
            default:         taken = 1'b1;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

### rtl/gve_datapath.sv
// gve_datapath: fix registers, stored state, shared multiplier, accumulator and divider.
// Depends on gve_pkg and gve_divider.
module gve_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  gve_pkg::lat_t    latitude,
    input  gve_pkg::lon_t    longitude,
    input  gve_pkg::dtime_t  delta_time_us,
    input  gve_pkg::scale_t  scale,
    input  gve_pkg::ctrl_t   ctrl,
    output logic             primed,
    output logic             div_busy,
    output gve_pkg::speed_t  emit_north,
    output gve_pkg::speed_t  emit_east
);
    import gve_pkg::*;

    lat_t               lat_reg;
    lon_t               lon_reg;
    dtime_t             dt_reg, dt_in;
    lat_t               last_lat_reg;
    lon_t               last_lon_reg;
    logic               primed_reg;
    speed_t             prev_n_reg, prev_e_reg;
    logic signed [31:0] dlat_reg;
    logic signed [32:0] dlon_reg;
    logic signed [63:0] prod_reg, acc_reg, acc_next;
    logic signed [32:0] mul_a;
    logic        [29:0] mul_b;
    logic signed [63:0] prod_w;
    denom_t             divisor;
    speed_t             div_q;

    // zero time counts as one; snap near 100 ms and 200 ms
    always_comb
    begin
        dt_in = (delta_time_us == '0) ? 20'd1 : delta_time_us;
        if (dt_in >= SNAP1_LO && dt_in <= SNAP1_HI)
        begin
            dt_in = SNAP1_VAL;
        end
        else if (dt_in >= SNAP2_LO && dt_in <= SNAP2_HI)
        begin
            dt_in = SNAP2_VAL;
        end
    end

    always_comb
    begin
        case (ctrl.mul_a)
            MA_DLAT:   mul_a = 33'(dlat_reg);
            MA_DLON:   mul_a = dlon_reg;
            MA_PREV_N: mul_a = 33'(prev_n_reg);
            MA_PREV_E: mul_a = 33'(prev_e_reg);
            MA_SCALE:  mul_a = $signed({17'd0, scale});
            default:   mul_a = '0;
        endcase
        case (ctrl.mul_b)
            MB_C1E6:   mul_b = K_1E6;
            MB_DT:     mul_b = {10'd0, dt_reg};
            MB_C15625: mul_b = K_15625;
            MB_PROD:   mul_b = prod_reg[29:0];   // scale * 15625 from the previous step
            default:   mul_b = '0;
        endcase
    end

    assign prod_w = 64'(mul_a * $signed({1'b0, mul_b}));

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD:     acc_next = prod_reg;
            ACC_ADD:      acc_next = acc_reg + prod_reg;
            ACC_ADD_SHL9: acc_next = acc_reg + (prod_reg <<< 9);
            default:      acc_next = acc_reg;
        endcase
    end

    assign divisor = ctrl.div_east ? {dt_reg, 10'd0} : {9'd0, dt_reg, 1'b0};

    gve_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .numer    (acc_reg),
        .denom    (divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lat_reg <= latitude;
            lon_reg <= longitude;
            dt_reg  <= dt_in;
        end
        if (ctrl.diff_en)
        begin
            dlat_reg <= 32'(lat_reg) - 32'(last_lat_reg);
            dlon_reg <= 33'(lon_reg) - 33'(last_lon_reg);
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_w;
        end
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_lat_reg <= '0;
            last_lon_reg <= '0;
            primed_reg   <= 1'b0;
            prev_n_reg   <= '0;
            prev_e_reg   <= '0;
        end
        else
        begin
            if (ctrl.commit)
            begin
                last_lat_reg <= lat_reg;
                last_lon_reg <= lon_reg;
                primed_reg   <= 1'b1;
            end
            if (ctrl.store_n)
            begin
                prev_n_reg <= div_q;
            end
            if (ctrl.store_e)
            begin
                prev_e_reg <= div_q;
            end
        end
    end

    assign primed     = primed_reg;
    assign emit_north = ctrl.emit_valid ? prev_n_reg : '0;
    assign emit_east  = ctrl.emit_valid ? prev_e_reg : '0;

endmodule

### rtl/gps_velocity_estimator.sv
// Priming fix: after its transfer it passes the check, prime-wait and prime-emit steps to
// the output register. Later fixes take two passes of the divider and the microprogram.
// Flow: one fix at a time; the next fix is taken once the sequencer is back at its idle
// step, even while a result waits in the output register.
// Reset (rst_n, async, active low): scale = 1.0, stored fix and speeds zero, not primed.
module gps_velocity_estimator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  gve_pkg::scale_t  cfg_wdata,
    gve_fix_if.sink          fix,
    gve_speed_if.source      speed
);
    import gve_pkg::*;

    scale_t  scale_reg;
    logic    out_valid_reg;
    speed_t  out_north_reg, out_east_reg;
    logic    out_sv_reg;
    ctrl_t   ctrl;
    stat_t   stat;
    logic    idle, in_fire, primed, div_busy;
    speed_t  emit_north, emit_east;

    assign fix.ready = idle;
    assign in_fire   = fix.valid && idle;

    assign stat = '{in_fire: in_fire, primed: primed, div_busy: div_busy,
                    out_full: out_valid_reg};

    gve_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .idle  (idle)
    );

    gve_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .latitude      (fix.latitude),
        .longitude     (fix.longitude),
        .delta_time_us (fix.delta_time_us),
        .scale         (scale_reg),
        .ctrl          (ctrl),
        .primed        (primed),
        .div_busy      (div_busy),
        .emit_north    (emit_north),
        .emit_east     (emit_east)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (speed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_north_reg <= emit_north;
            out_east_reg  <= emit_east;
            out_sv_reg    <= ctrl.emit_valid;
        end
    end

    assign speed.valid       = out_valid_reg;
    assign speed.speed_north = out_north_reg;
    assign speed.speed_east  = out_east_reg;
    assign speed.speed_valid = out_sv_reg;

endmodule

### rtl/gve_checker.sv
// gve_checker: port-level checks for the GPS velocity estimator, bound to the top level.
// Depends on gve_pkg for payload types.
module gve_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  gve_pkg::speed_t speed_north,
    input  gve_pkg::speed_t speed_east,
    input  logic            speed_valid
);
    import gve_pkg::*;

    logic       in_xfer, out_xfer;
    logic [1:0] pend_reg, pend_next;
    logic       seen_reg;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_xfer)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a pending fix");

    a_prime_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> speed_valid == seen_reg)
        else $error("speed_valid wrong for priming or later fix");

    a_prime_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !speed_valid |-> speed_north == '0 && speed_east == '0)
        else $error("priming result carries nonzero speed");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !in_ready)
        else $error("fix taken with two results outstanding");

endmodule

bind gps_velocity_estimator gve_checker u_gve_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (fix.valid),
    .in_ready    (fix.ready),
    .out_valid   (speed.valid),
    .out_ready   (speed.ready),
    .speed_north (speed.speed_north),
    .speed_east  (speed.speed_east),
    .speed_valid (speed.speed_valid)
);
